/* rtl/fsos_pkg.sv */
package fsos_pkg;

	localparam int NumFreqs  = 4;
	localparam int AmpLevels = 32;
	localparam int FreqW     = 18;

	typedef enum logic [1:0] {
		SRC_SILENCE    = 2'd0,
		SRC_ASPIRATION = 2'd1,
		SRC_FRICATION  = 2'd2,
		SRC_BUZZ       = 2'd3
	} source_t;

	typedef enum logic [1:0] {
		KIND_SILENCE  = 2'd0,
		KIND_HARMONIC = 2'd1,
		KIND_NOISE    = 2'd2,
		KIND_UNUSED   = 2'd3
	} kind_t;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_SLICE = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] start_f0;
		logic [15:0] start_f1;
		logic [15:0] start_f2;
		logic [15:0] start_f3;
		logic [15:0] end_f0;
		logic [15:0] end_f1;
		logic [15:0] end_f2;
		logic [15:0] end_f3;
		logic [14:0] slice_count;
		logic [1:0]  source;
		logic [15:0] base_phase;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  osc_index;
		logic [15:0] osc_freq;
		logic [15:0] osc_phase;
		logic [4:0]  amp_index;
		logic        phase_reset;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOAD_DIV,
		ST_LOAD_WAIT,
		ST_EMIT_SIMPLE,
		ST_H_DIV,
		ST_H_WAIT,
		ST_A_DIV,
		ST_A_WAIT,
		ST_EMIT0,
		ST_EMIT1,
		ST_ADVANCE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       load_div_start;
		logic       load_write;
		logic       h_div_start;
		logic       h_capture;
		logic       a_div_start;
		logic       emit0;
		logic       emit1;
		logic       emit_simple;
		logic       advance;
		logic [1:0] idx;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       div_done;
		logic       is_load;
		logic       single_slice;
		logic [1:0] source;
		logic       out_busy;
	} dp_status_t;

endpackage

/* rtl/fsos_divider.sv */
// Restoring divider for a 32-bit dividend and a 16-bit divisor, one bit a cycle.
// Quotient and remainder hold from the done pulse until the next start.
module fsos_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [15:0] remainder
);
	logic [31:0] quot_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q, quot_q[31]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};

	// Iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle while busy.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q  <= diff[15:0];
				quot_q <= {quot_q[30:0], 1'b1};
			end else begin
				rem_q  <= trial[15:0];
				quot_q <= {quot_q[30:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;
endmodule

/* rtl/fsos_datapath.sv */
// Frequency state, ramp arithmetic, harmonic math and output register.
module fsos_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsos_pkg::in_item_t   in_item,
	input  fsos_pkg::dp_cmd_t    cmd,
	output fsos_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fsos_pkg::out_item_t  out_item
);
	logic signed [17:0]  cur_q   [fsos_pkg::NumFreqs];
	logic signed [17:0]  slope_q [fsos_pkg::NumFreqs];
	logic [1:0]          src_q;
	fsos_pkg::in_item_t  item_q;
	logic                out_valid_q;
	fsos_pkg::out_item_t out_q;
	fsos_pkg::out_item_t out_d;

	logic [15:0] f0_q, ff_q, h_q, fh0_q, gap_q;
	logic [4:0]  amp_q;
	logic [2:0]  n_q;

	logic        div_start, div_done;
	logic [31:0] div_dividend, div_quot;
	logic [15:0] div_divisor, div_rem;

	logic [15:0]        sa, sb, a_e, b_e;
	logic signed [17:0] diff;
	logic [16:0]        mag, mag_sel;
	logic signed [17:0] step;
	logic [14:0]        cnt;
	logic               single;

	logic [15:0] fsel, f0_now;
	logic [20:0] num;
	logic        f0_zero;
	logic [16:0] fh1;
	logic [31:0] ph_full;
	logic [15:0] ph0;
	logic [4:0]  a0, a1;
	logic        emit;

	// Clamped current frequency per entry.
	function automatic logic [15:0] clamp(input logic signed [17:0] v);
		if (v[17]) return 16'd0;
		if (v[16]) return 16'hFFFF;
		return v[15:0];
	endfunction

	// Endpoints of the selected entry with zero substitution, and the ramp step.
	always_comb begin
		unique case (cmd.idx)
			2'd0: begin sa = item_q.start_f0; sb = item_q.end_f0; end
			2'd1: begin sa = item_q.start_f1; sb = item_q.end_f1; end
			2'd2: begin sa = item_q.start_f2; sb = item_q.end_f2; end
			default: begin sa = item_q.start_f3; sb = item_q.end_f3; end
		endcase
		a_e     = (sa == 16'd0) ? sb : sa;
		b_e     = (sb == 16'd0) ? a_e : sb;
		diff    = $signed({2'b00, b_e}) - $signed({2'b00, a_e});
		mag     = diff[17] ? 17'(-diff) : diff[16:0];
		cnt     = (item_q.slice_count == 15'd0) ? 15'd1 : item_q.slice_count;
		single  = (cnt == 15'd1);
		// A single slice starts at the midpoint, so the step is half the difference.
		mag_sel = single ? (mag >> 1) : div_quot[16:0];
		step    = diff[17] ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
	end

	assign fsel   = clamp(cur_q[cmd.idx]);
	assign f0_now = clamp(cur_q[0]);

	// Amplitude numerator: amp times the gap from the formant to the upper harmonic.
	assign num = {16'd0, amp_q} * {5'd0, gap_q};

	// Divider operand selection.
	always_comb begin
		div_start = cmd.load_div_start | cmd.h_div_start | cmd.a_div_start;
		if (cmd.load_div_start) begin
			div_dividend = {15'd0, mag};
			div_divisor  = 16'(cnt - 15'd1);
		end else if (cmd.h_div_start) begin
			div_dividend = {16'd0, fsel};
			div_divisor  = f0_now;
		end else begin
			div_dividend = {11'd0, num};
			div_divisor  = f0_q;
		end
	end

	fsos_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Harmonic pair values; a zero fundamental gives zero frequencies and amplitudes.
	assign f0_zero = (f0_q == 16'd0);
	assign fh1     = {1'b0, fh0_q} + {1'b0, f0_q};
	assign ph_full = h_q * item_q.base_phase;
	assign ph0     = ph_full[15:0];
	assign a0      = f0_zero ? 5'd0 : div_quot[4:0];
	assign a1      = f0_zero ? 5'd0 : amp_q - div_quot[4:0];
	assign emit    = cmd.emit0 | cmd.emit1 | cmd.emit_simple;

	// Next output item.
	always_comb begin
		out_d           = '0;
		out_d.osc_index = n_q;
		if (cmd.emit0) begin
			out_d.kind      = fsos_pkg::KIND_HARMONIC;
			out_d.osc_freq  = fh0_q;
			out_d.osc_phase = ph0;
			out_d.amp_index = a0;
		end else if (cmd.emit1) begin
			out_d.kind      = fsos_pkg::KIND_HARMONIC;
			out_d.osc_freq  = fh1[16] ? 16'hFFFF : fh1[15:0];
			out_d.osc_phase = ph0 + item_q.base_phase;
			out_d.amp_index = a1;
			out_d.last      = (cmd.idx == 2'(fsos_pkg::NumFreqs - 1));
		end else if (src_q == fsos_pkg::SRC_SILENCE) begin
			out_d.kind      = fsos_pkg::KIND_SILENCE;
			out_d.osc_index = '0;
			out_d.last      = 1'b1;
		end else if (src_q == fsos_pkg::SRC_BUZZ) begin
			out_d.kind      = fsos_pkg::KIND_HARMONIC;
			out_d.osc_freq  = f0_now;
			out_d.osc_phase = item_q.base_phase;
		end else begin
			out_d.kind        = fsos_pkg::KIND_NOISE;
			out_d.osc_freq    = fsel;
			out_d.phase_reset = (fsel == 16'd0);
			out_d.last        = (cmd.idx == 2'd0);
		end
	end

	// Segment state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fsos_pkg::NumFreqs; i++) begin
				cur_q[i]   <= '0;
				slope_q[i] <= '0;
			end
			src_q       <= fsos_pkg::SRC_SILENCE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture && in_item.mode == fsos_pkg::MODE_LOAD) src_q <= in_item.source;
			if (cmd.load_write) begin
				if (a_e == 16'd0 ||
				    (cmd.idx == 2'd0 && src_q == fsos_pkg::SRC_ASPIRATION)) begin
					cur_q[cmd.idx]   <= '0;
					slope_q[cmd.idx] <= '0;
				end else if (single) begin
					cur_q[cmd.idx]   <= $signed({2'b00, a_e}) + step;
					slope_q[cmd.idx] <= '0;
				end else begin
					cur_q[cmd.idx]   <= $signed({2'b00, a_e});
					slope_q[cmd.idx] <= step;
				end
			end
			if (cmd.advance) begin
				for (int i = 0; i < fsos_pkg::NumFreqs; i++)
					cur_q[i] <= cur_q[i] + slope_q[i];
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Item, harmonic working registers and output payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
			n_q    <= '0;
			amp_q  <= 5'(fsos_pkg::AmpLevels - 1);
		end
		if (cmd.h_div_start) begin
			f0_q <= f0_now;
			ff_q <= fsel;
		end
		if (cmd.h_capture) begin
			h_q   <= f0_zero ? 16'd0 : div_quot[15:0];
			fh0_q <= f0_zero ? 16'd0 : ff_q - div_rem;
			gap_q <= f0_zero ? 16'd0 : f0_q - div_rem;
		end
		if (emit) begin
			n_q   <= n_q + 3'd1;
			out_q <= out_d;
		end
		if (cmd.emit1) amp_q <= 5'(({2'b00, amp_q} * 7'd3) >> 2);
	end

	assign status.div_done     = div_done;
	assign status.is_load      = (item_q.mode == fsos_pkg::MODE_LOAD);
	assign status.single_slice = single;
	assign status.source       = src_q;
	assign status.out_busy     = out_valid_q & ~out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule

/* rtl/fsos_controller.sv */
// Sequencer for load and slice processing.
module fsos_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fsos_pkg::dp_status_t  status,
	output fsos_pkg::dp_cmd_t     cmd
);
	fsos_pkg::state_t st_q, st_d;
	logic [1:0] idx_q, idx_d;

	// Next state.
	always_comb begin
		st_d  = st_q;
		idx_d = idx_q;
		unique case (st_q)
			fsos_pkg::ST_IDLE:
				if (in_valid) st_d = fsos_pkg::ST_DECODE;
			fsos_pkg::ST_DECODE: begin
				idx_d = '0;
				if (status.is_load) st_d = fsos_pkg::ST_LOAD_DIV;
				else begin
					st_d = fsos_pkg::ST_EMIT_SIMPLE;
					if (status.source == fsos_pkg::SRC_ASPIRATION ||
					    status.source == fsos_pkg::SRC_FRICATION) idx_d = 2'd1;
				end
			end
			fsos_pkg::ST_LOAD_DIV:
				if (status.single_slice) begin
					idx_d = idx_q + 2'd1;
					if (idx_q == 2'(fsos_pkg::NumFreqs - 1)) st_d = fsos_pkg::ST_IDLE;
				end else begin
					st_d = fsos_pkg::ST_LOAD_WAIT;
				end
			fsos_pkg::ST_LOAD_WAIT:
				if (status.div_done) begin
					idx_d = idx_q + 2'd1;
					st_d = (idx_q == 2'(fsos_pkg::NumFreqs - 1)) ? fsos_pkg::ST_IDLE :
					       fsos_pkg::ST_LOAD_DIV;
				end
			fsos_pkg::ST_EMIT_SIMPLE:
				if (!status.out_busy) begin
					if (status.source == fsos_pkg::SRC_SILENCE) st_d = fsos_pkg::ST_ADVANCE;
					else if (status.source == fsos_pkg::SRC_BUZZ) begin
						idx_d = 2'd1; st_d = fsos_pkg::ST_H_DIV;
					end else if (idx_q == 2'd0) st_d = fsos_pkg::ST_ADVANCE;
					else idx_d = (idx_q == 2'd3) ? 2'd0 : idx_q + 2'd1;
				end
			fsos_pkg::ST_H_DIV: st_d = fsos_pkg::ST_H_WAIT;
			fsos_pkg::ST_H_WAIT: if (status.div_done) st_d = fsos_pkg::ST_A_DIV;
			fsos_pkg::ST_A_DIV: st_d = fsos_pkg::ST_A_WAIT;
			fsos_pkg::ST_A_WAIT: if (status.div_done) st_d = fsos_pkg::ST_EMIT0;
			fsos_pkg::ST_EMIT0: if (!status.out_busy) st_d = fsos_pkg::ST_EMIT1;
			fsos_pkg::ST_EMIT1:
				if (!status.out_busy) begin
					if (idx_q == 2'(fsos_pkg::NumFreqs - 1)) st_d = fsos_pkg::ST_ADVANCE;
					else begin idx_d = idx_q + 2'd1; st_d = fsos_pkg::ST_H_DIV; end
				end
			fsos_pkg::ST_ADVANCE: st_d = fsos_pkg::ST_IDLE;
			default: st_d = fsos_pkg::ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		in_ready = (st_q == fsos_pkg::ST_IDLE);
		cmd.capture = in_ready & in_valid;
		unique case (st_q)
			fsos_pkg::ST_LOAD_DIV: begin
				cmd.load_div_start = ~status.single_slice;
				cmd.load_write     = status.single_slice;
			end
			fsos_pkg::ST_LOAD_WAIT:   cmd.load_write = status.div_done;
			fsos_pkg::ST_H_DIV:       cmd.h_div_start = 1'b1;
			fsos_pkg::ST_H_WAIT:      cmd.h_capture = status.div_done;
			fsos_pkg::ST_A_DIV:       cmd.a_div_start = 1'b1;
			fsos_pkg::ST_EMIT0:       cmd.emit0 = ~status.out_busy;
			fsos_pkg::ST_EMIT1:       cmd.emit1 = ~status.out_busy;
			fsos_pkg::ST_EMIT_SIMPLE: cmd.emit_simple = ~status.out_busy;
			fsos_pkg::ST_ADVANCE:     cmd.advance = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= fsos_pkg::ST_IDLE;
			idx_q <= '0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
		end
	end
endmodule

/* rtl/formant_slice_oscillator_setup_core.sv */
// Channel | Direction | Handshake
// in      | input     | in_valid / in_ready, payload in_item
// out     | output    | out_valid / out_ready, payload out_item
//
// All divides share the one-bit-a-cycle divider. A buzz slice makes two
// divides for each formant above the fundamental; a load makes one per
// entry, and none when it has a single slice.
// Input is ready only between items; a held output register pauses the sequencer.
// Reset clears all frequencies and slopes, sets the source to silence and
// empties the output register.
module formant_slice_oscillator_setup_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fsos_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fsos_pkg::out_item_t out_item
);
	fsos_pkg::dp_cmd_t    cmd;
	fsos_pkg::dp_status_t status;

	fsos_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	fsos_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .status(status),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	localparam int FW = fsos_pkg::FreqW;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	fsos_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready;
	fsos_pkg::out_item_t out_item;

	formant_slice_oscillator_setup_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// Predictor state: ramp position, ramp slope and segment source.
	logic signed [FW-1:0] ramp_freq [fsos_pkg::NumFreqs];
	logic signed [FW-1:0] ramp_slope[fsos_pkg::NumFreqs];
	logic [1:0]           seg_source;

	fsos_pkg::in_item_t  pending_items[$];
	fsos_pkg::out_item_t osc_settings_due[$];
	int                  total_items;
	int                  sent_count;
	int                  err_count;
	bit                  recv_hold;

	// Clock and reset.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [15:0] sat16(logic signed [FW-1:0] v);
		if (v < 0)
			return 16'd0;
		if (v > 65535)
			return 16'hFFFF;
		return v[15:0];
	endfunction

	function automatic fsos_pkg::out_item_t mk_osc(logic [1:0] kind, int idx, longint freq,
		longint phase, int amp, bit rst);
		fsos_pkg::out_item_t o;
		o.kind        = kind;
		o.osc_index   = idx[2:0];
		o.osc_freq    = (freq > 65535) ? 16'hFFFF : freq[15:0];
		o.osc_phase   = phase[15:0];
		o.amp_index   = amp[4:0];
		o.phase_reset = rst;
		o.last        = 1'b0;
		return o;
	endfunction

	// Work out the oscillator settings caused by one accepted item.
	task automatic predict_settings(fsos_pkg::in_item_t it);
		int                  cnt, a, b, n;
		longint              f[fsos_pkg::NumFreqs];
		longint              f0, ff, h, fh0, fh1, a0, a1, amp, p0;
		logic [15:0]         sv [8];
		fsos_pkg::out_item_t res[$];
		sv[0] = it.start_f0; sv[1] = it.start_f1; sv[2] = it.start_f2; sv[3] = it.start_f3;
		sv[4] = it.end_f0;   sv[5] = it.end_f1;   sv[6] = it.end_f2;   sv[7] = it.end_f3;
		if (it.mode == fsos_pkg::MODE_LOAD) begin
			cnt = (it.slice_count == 15'd0) ? 1 : int'(it.slice_count);
			for (int i = 0; i < fsos_pkg::NumFreqs; i++) begin
				a = int'(sv[i]);
				b = int'(sv[4 + i]);
				if (a == 0)
					a = b;
				else if (b == 0)
					b = a;
				ramp_freq[i]  = FW'(a);
				ramp_slope[i] = '0;
				if (a != 0) begin
					if (cnt == 1)
						ramp_freq[i] = FW'(a + (b - a) / 2);
					else
						ramp_slope[i] = FW'((b - a) / (cnt - 1));
				end
			end
			seg_source = it.source;
			if (seg_source == fsos_pkg::SRC_ASPIRATION) begin
				ramp_freq[0]  = '0;
				ramp_slope[0] = '0;
			end
			return;
		end
		for (int i = 0; i < fsos_pkg::NumFreqs; i++)
			f[i] = longint'(sat16(ramp_freq[i]));
		if (seg_source == fsos_pkg::SRC_SILENCE) begin
			res.push_back(mk_osc(fsos_pkg::KIND_SILENCE, 0, 0, 0, 0, 1'b0));
		end else if (seg_source == fsos_pkg::SRC_BUZZ) begin
			p0  = longint'(it.base_phase);
			f0  = f[0];
			amp = longint'(fsos_pkg::AmpLevels - 1);
			res.push_back(mk_osc(fsos_pkg::KIND_HARMONIC, 0, f0, p0, 0, 1'b0));
			for (int i = 1; i < fsos_pkg::NumFreqs; i++) begin
				h = 0; fh0 = 0; fh1 = 0; a0 = 0; a1 = 0;
				if (f0 != 0) begin
					ff  = f[i];
					h   = ff / f0;
					fh0 = h * f0;
					fh1 = fh0 + f0;
					a0  = amp * (fh1 - ff) / f0;
					a1  = amp - a0;
				end
				amp = amp * 3 / 4;
				n = res.size();
				res.push_back(mk_osc(fsos_pkg::KIND_HARMONIC, n, fh0, h * p0, int'(a0), 1'b0));
				res.push_back(mk_osc(fsos_pkg::KIND_HARMONIC, n + 1, fh1, (h + 1) * p0,
					int'(a1), 1'b0));
			end
		end else begin
			for (int i = 1; i < fsos_pkg::NumFreqs; i++)
				res.push_back(mk_osc(fsos_pkg::KIND_NOISE, i - 1, f[i], 0, 0, f[i] == 0));
			res.push_back(mk_osc(fsos_pkg::KIND_NOISE, fsos_pkg::NumFreqs - 1, f[0], 0, 0,
				f[0] == 0));
		end
		res[res.size() - 1].last = 1'b1;
		foreach (res[k])
			osc_settings_due.push_back(res[k]);
		for (int i = 0; i < fsos_pkg::NumFreqs; i++)
			ramp_freq[i] = ramp_freq[i] + ramp_slope[i];
	endtask

	function automatic fsos_pkg::in_item_t rand_item();
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return bits[$bits(fsos_pkg::in_item_t)-1:0];
	endfunction

	task automatic add_load(int s0, int s1, int s2, int s3, int e0, int e1, int e2, int e3,
		int cnt, logic [1:0] src);
		fsos_pkg::in_item_t it;
		it = rand_item();
		it.mode = fsos_pkg::MODE_LOAD;
		it.start_f0 = 16'(s0); it.start_f1 = 16'(s1);
		it.start_f2 = 16'(s2); it.start_f3 = 16'(s3);
		it.end_f0 = 16'(e0);   it.end_f1 = 16'(e1);
		it.end_f2 = 16'(e2);   it.end_f3 = 16'(e3);
		it.slice_count = 15'(cnt);
		it.source = src;
		pending_items.push_back(it);
	endtask

	task automatic add_slice(int phase);
		fsos_pkg::in_item_t it;
		it = rand_item();
		it.mode = fsos_pkg::MODE_SLICE;
		it.base_phase = 16'(phase);
		pending_items.push_back(it);
	endtask

	function automatic int rand_freq();
		case ($urandom_range(5))
			0: return 0;
			1: return int'($urandom_range(65535));
			2: return int'($urandom_range(65535, 60000));
			default: return int'($urandom_range(3000, 1));
		endcase
	endfunction

	// Stimulus: directed corners first, then random segments with noise items.
	initial begin
		int segs, cnt;
		add_slice(16'h1234);
		add_load(100, 700, 1500, 2500, 200, 900, 1300, 2600, 4, fsos_pkg::SRC_BUZZ);
		add_slice(0); add_slice(16'hFFFF); add_slice(16'h8001);
		add_load(0, 65535, 0, 1, 65535, 0, 0, 65535, 1, fsos_pkg::SRC_BUZZ);
		add_slice(16'hFFFF);
		add_load(0, 0, 0, 0, 0, 0, 0, 0, 0, fsos_pkg::SRC_BUZZ);
		add_slice(16'h5555);
		add_load(65535, 65535, 1, 65535, 1, 1, 65535, 1, 32767, fsos_pkg::SRC_FRICATION);
		add_slice(7); add_slice(9);
		add_load(300, 1000, 0, 65535, 500, 3000, 4000, 0, 2, fsos_pkg::SRC_ASPIRATION);
		add_slice(1); add_slice(2); add_slice(3);
		// Ramp running past the segment end so the position wraps.
		add_load(65535, 65535, 1, 60000, 1, 1, 65535, 65535, 2, fsos_pkg::SRC_FRICATION);
		add_slice(0); add_slice(0); add_slice(0); add_slice(0);
		add_load(1, 65535, 65534, 2, 1, 65535, 65534, 2, 3, fsos_pkg::SRC_BUZZ);
		add_slice(16'hAAAA);
		add_load(500, 600, 700, 800, 500, 600, 700, 800, 5, fsos_pkg::SRC_SILENCE);
		add_slice(16'h0F0F);
		while (pending_items.size() < 500) begin
			if ($urandom_range(9) == 0) begin
				pending_items.push_back(rand_item());
			end else begin
				cnt = ($urandom_range(7) == 0) ? int'($urandom_range(32767)) :
					int'($urandom_range(8));
				add_load(rand_freq(), rand_freq(), rand_freq(), rand_freq(),
					rand_freq(), rand_freq(), rand_freq(), rand_freq(),
					cnt, 2'($urandom_range(3)));
				segs = int'($urandom_range(6, 1));
				for (int k = 0; k < segs; k++)
					add_slice(int'($urandom_range(65535)));
			end
		end
		total_items = pending_items.size();
	end

	function automatic int phase_now();
		return (total_items == 0) ? 0 : sent_count * 4 / total_items;
	endfunction

	// Driver: predict on each input transfer, then offer the next item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_item    <= '0;
			sent_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_settings(in_item);
				sent_count <= sent_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 &&
					$urandom_range(99) >= ((phase_now() == 1) ? 55 :
					(phase_now() == 3) ? 32 : 0)) begin
					in_valid <= 1'b1;
					in_item  <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each output transfer against the oldest expected setting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			err_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (osc_settings_due.size() == 0) begin
					err_count <= err_count + 1;
					if (err_count < 10)
						$display("unexpected transfer: %p", out_item);
				end else if (out_item !== osc_settings_due[0]) begin
					err_count <= err_count + 1;
					if (err_count < 10)
						$display("mismatch: expected %p actual %p", osc_settings_due[0],
							out_item);
					void'(osc_settings_due.pop_front());
				end else begin
					void'(osc_settings_due.pop_front());
				end
			end
			out_ready <= !recv_hold && ($urandom_range(99) >= ((phase_now() == 2) ? 55 :
				(phase_now() == 3) ? 32 : 0));
		end
	end

	// Long receiver hold-off while the sender keeps offering items.
	initial begin
		recv_hold = 1'b0;
		@(posedge arst_n);
		while (sent_count < 40)
			@(posedge clk);
		recv_hold = 1'b1;
		repeat (3000) @(posedge clk);
		recv_hold = 1'b0;
	end

	// End of run.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (pending_items.size() > 0 || in_valid)
			@(posedge clk);
		while (osc_settings_due.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (err_count == 0 && osc_settings_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
